>>> sv/amqp_scan_pkg.sv
package amqp_scan_pkg;

    // Scan phase within one message
    typedef enum logic [1:0] {
        PH_DESC,
        PH_TAG,
        PH_LEN,
        PH_SKIP
    } scan_phase_t;

    // Tag set allowed for a section
    typedef enum logic [1:0] {
        CLS_LIST,
        CLS_MAP,
        CLS_BIN
    } tag_class_t;

    // Descriptor bytes
    localparam logic [7:0] DESC_LEAD    = 8'h00;
    localparam logic [7:0] DESC_SHORT   = 8'h53;
    localparam logic [7:0] DESC_LONG    = 8'h80;
    localparam logic [7:0] CODE_HEADER  = 8'h70;
    localparam logic [7:0] CODE_BODYSEQ = 8'h76;
    localparam logic [7:0] CODE_FOOTER  = 8'h78;
    localparam logic [3:0] LONG_CODE_AT = 4'd9;

    // Type tags
    localparam logic [7:0] TAG_LIST0  = 8'h45;
    localparam logic [7:0] TAG_LIST8  = 8'hc0;
    localparam logic [7:0] TAG_LIST32 = 8'hd0;
    localparam logic [7:0] TAG_MAP8   = 8'hc1;
    localparam logic [7:0] TAG_MAP32  = 8'hd1;
    localparam logic [7:0] TAG_VBIN8  = 8'ha0;
    localparam logic [7:0] TAG_VBIN32 = 8'hb0;

    // Section ids, result kinds, length sizes and depth settings
    localparam logic [2:0] SEC_FOOTER     = 3'd7;
    localparam logic [2:0] SEC_NONE       = 3'd0;
    localparam logic       KIND_REPORT    = 1'b0;
    localparam logic       KIND_VERDICT   = 1'b1;
    localparam logic [2:0] LEN_BYTES_8    = 3'd1;
    localparam logic [2:0] LEN_BYTES_32   = 3'd4;
    localparam logic [2:0] DEPTH_ALL      = 3'd7;
    localparam logic [2:0] DEPTH_NONE     = 3'd0;

    // Scan state that is rearmed per message
    typedef struct packed {
        logic [4:0]  check_position;
        scan_phase_t phase;
        logic [3:0]  desc_count;
        logic        desc_long;
        logic [31:0] len_acc;
        logic [2:0]  len_left;
        logic [31:0] skip_rem;
        logic [7:0]  seen;
        logic        invalid;
        logic        stopped;
    } scan_state_t;

    function automatic scan_state_t scan_arm(input logic [2:0] depth);
        scan_state_t s;
        s.check_position = '0;
        s.phase          = PH_DESC;
        s.desc_count     = '0;
        s.desc_long      = 1'b0;
        s.len_acc        = '0;
        s.len_left       = '0;
        s.skip_rem       = '0;
        s.seen           = '0;
        s.invalid        = 1'b0;
        s.stopped        = (depth == DEPTH_NONE);
        return s;
    endfunction

    // Last check index allowed by a depth setting
    function automatic logic [3:0] last_check(input logic [2:0] depth);
        logic [3:0] r;
        unique case (depth)
            3'd0:    r = 4'd0;
            3'd1:    r = 4'd1;
            3'd2:    r = 4'd3;
            3'd3:    r = 4'd5;
            3'd4:    r = 4'd7;
            3'd5:    r = 4'd9;
            3'd6:    r = 4'd13;
            default: r = 4'd15;
        endcase
        return r;
    endfunction

    function automatic tag_class_t section_class(input logic [2:0] id);
        tag_class_t c;
        unique case (id)
            3'd0, 3'd3, 3'd6: c = CLS_LIST;
            3'd5:             c = CLS_BIN;
            default:          c = CLS_MAP;
        endcase
        return c;
    endfunction

    function automatic logic tag_ok(input tag_class_t c, input logic [7:0] t);
        logic r;
        unique case (c)
            CLS_LIST: r = (t == TAG_LIST0) || (t == TAG_LIST8) || (t == TAG_LIST32);
            CLS_MAP:  r = (t == TAG_MAP8) || (t == TAG_MAP32);
            CLS_BIN:  r = (t == TAG_VBIN8) || (t == TAG_VBIN32);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/amqp_scan_if.sv
// Byte channel into the scanner
interface amqp_scan_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic [2:0] depth_limit;

    modport source (output valid, data_byte, first_byte, last_byte, depth_limit,
                    input ready);
    modport sink (input valid, data_byte, first_byte, last_byte, depth_limit,
                  output ready);
endinterface

// Result channel out of the scanner
interface amqp_scan_out_if #(
    parameter int OFFSET_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic                   result_kind;
    logic [2:0]             section_id;
    logic [OFFSET_BITS-1:0] tag_offset;
    logic                   message_valid;
    logic                   last_result;

    modport source (output valid, result_kind, section_id, tag_offset, message_valid,
                    last_result, input ready);
    modport sink (input valid, result_kind, section_id, tag_offset, message_valid,
                  last_result, output ready);
endinterface

>>> sv/amqp_message_section_scanner.sv
// AMQP 1.0 message section scanner.
// byte_ch (sink): one message byte per item, with first_byte / last_byte marks;
//   depth_limit is sampled with first_byte. A byte without a first mark after
//   reset or after a last byte starts a new message at offset 0.
// result_ch (source): section reports (result_kind 0: section_id, tag_offset of
//   the type tag) and one verdict per message (result_kind 1: message_valid).
//   last_result marks the final result caused by a byte.
// Throughput: one byte per cycle while the queue has room for two results. Each
//   byte updates the scan state in the cycle it is accepted; its results (zero,
//   one or two) enter a 4-entry result queue, are registered there and only then
//   appear on result_ch. A byte that causes two results (report plus verdict) needs
//   two pops on the output side, so the queue, which takes a byte only while it has
//   room for two results, sets the rate when results come faster than one per cycle.
// Reset: asynchronous, active low; empties the queue, rearms the scan with
//   depth 7 (all sections).
// Stall: while result_ch.ready is low the queue holds its items and byte_ch
//   keeps taking bytes until fewer than two queue slots are free.
module amqp_message_section_scanner
    import amqp_scan_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)(
    input  logic              clk,
    input  logic              rst_n,
    amqp_scan_in_if.sink      byte_ch,
    amqp_scan_out_if.source   result_ch
);

    localparam int ITEM_W = OFFSET_BITS + 6;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    scan_state_t            st_reg, st_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [2:0]             depth_reg, depth_next;

    logic [ITEM_W-1:0]      queue_reg [QDEPTH];
    logic [QPTR_W-1:0]      wr_reg, rd_reg;
    logic [QPTR_W:0]        count_reg, count_next;

    logic                   accept, pop;
    logic [1:0]             push_n;
    logic [ITEM_W-1:0]      item0, item1, head;

    // Per-byte scan work
    logic                   rep_hit;
    logic [2:0]             rep_id;
    logic [OFFSET_BITS-1:0] rep_off;
    logic                   verdict_ok;
    logic [7:0]             b;
    logic                   code_ok;
    logic [2:0]             code_id;
    logic [3:0]             k;
    logic [4:0]             cp_m1;
    logic [2:0]             tag_id;
    logic [ITEM_W-1:0]      rep_item, ver_item;

    assign accept = byte_ch.valid && byte_ch.ready;
    assign pop    = result_ch.valid && result_ch.ready;
    assign b      = byte_ch.data_byte;

    always_comb
    begin
        st_next     = st_reg;
        offset_next = offset_reg;
        depth_next  = depth_reg;
        rep_hit     = 1'b0;
        rep_off     = offset_reg;
        verdict_ok  = 1'b0;
        code_ok     = 1'b0;
        code_id     = SEC_NONE;
        k           = '0;

        // first byte restarts the scan
        if (byte_ch.first_byte)
        begin
            depth_next  = byte_ch.depth_limit;
            st_next     = scan_arm(byte_ch.depth_limit);
            offset_next = '0;
        end
        rep_off = offset_next;

        cp_m1  = st_next.check_position - 5'd1;
        tag_id = cp_m1[3:1];

        if (!st_next.stopped)
        begin
            case (st_next.phase)
                PH_DESC:
                begin
                    if (st_next.desc_count == 4'd0)
                    begin
                        if (b != DESC_LEAD)
                            st_next.stopped = 1'b1;
                        else
                            st_next.desc_count = 4'd1;
                    end
                    else if (st_next.desc_count == 4'd1)
                    begin
                        if (b == DESC_LONG)
                        begin
                            st_next.desc_long  = 1'b1;
                            st_next.desc_count = 4'd2;
                        end
                        else if (b == DESC_SHORT)
                        begin
                            st_next.desc_long  = 1'b0;
                            st_next.desc_count = 4'd2;
                        end
                        else
                            st_next.stopped = 1'b1;
                    end
                    else if (st_next.desc_long && st_next.desc_count < LONG_CODE_AT)
                    begin
                        if (b != DESC_LEAD)
                            st_next.stopped = 1'b1;
                        else
                            st_next.desc_count = st_next.desc_count + 4'd1;
                    end
                    else
                    begin
                        // descriptor code: map to section, then to ordered check
                        if (b >= CODE_HEADER && b <= CODE_BODYSEQ)
                        begin
                            code_ok = 1'b1;
                            code_id = 3'(b - CODE_HEADER);
                        end
                        else if (b == CODE_FOOTER)
                        begin
                            code_ok = 1'b1;
                            code_id = SEC_FOOTER;
                        end
                        k = {code_id, ~st_next.desc_long};
                        if (!code_ok || ({1'b0, k} < st_next.check_position)
                            || (k > last_check(depth_next)))
                            st_next.stopped = 1'b1;
                        else
                        begin
                            st_next.check_position = {1'b0, k} + 5'd1;
                            st_next.desc_count     = 4'd0;
                            st_next.phase          = PH_TAG;
                        end
                    end
                end
                PH_TAG:
                begin
                    if (!tag_ok(section_class(tag_id), b) || st_next.seen[tag_id])
                    begin
                        st_next.invalid = 1'b1;
                        st_next.stopped = 1'b1;
                    end
                    else
                    begin
                        st_next.seen[tag_id] = 1'b1;
                        rep_hit = 1'b1;
                        if (byte_ch.last_byte)
                        begin
                            st_next.invalid = 1'b1;
                            st_next.stopped = 1'b1;
                        end
                        else
                        begin
                            st_next.len_acc = '0;
                            if (b == TAG_LIST0)
                                st_next.phase = PH_DESC;
                            else
                            begin
                                st_next.len_left = (b == TAG_LIST8 || b == TAG_MAP8
                                                    || b == TAG_VBIN8)
                                                   ? LEN_BYTES_8 : LEN_BYTES_32;
                                st_next.phase = PH_LEN;
                            end
                        end
                    end
                end
                PH_LEN:
                begin
                    st_next.len_acc  = {st_next.len_acc[23:0], b};
                    st_next.len_left = st_next.len_left - 3'd1;
                    if (byte_ch.last_byte)
                    begin
                        st_next.invalid = 1'b1;
                        st_next.stopped = 1'b1;
                    end
                    else if (st_next.len_left == 3'd0)
                    begin
                        st_next.skip_rem = st_next.len_acc;
                        st_next.phase = (st_next.len_acc == 32'd0) ? PH_DESC : PH_SKIP;
                    end
                end
                default:
                begin
                    st_next.skip_rem = st_next.skip_rem - 32'd1;
                    if (st_next.skip_rem == 32'd0)
                        st_next.phase = PH_DESC;
                end
            endcase
        end

        // last byte gives the verdict and rearms with the held depth
        if (byte_ch.last_byte)
        begin
            verdict_ok  = !st_next.invalid;
            st_next     = scan_arm(depth_next);
            offset_next = '0;
        end
        else
            offset_next = offset_next + 1'b1;
    end

    // Result items: kind, id, offset, valid, last
    assign rep_id   = tag_id;
    assign rep_item = {KIND_REPORT, rep_id, rep_off, 1'b0, !byte_ch.last_byte};
    assign ver_item = {KIND_VERDICT, SEC_NONE, {OFFSET_BITS{1'b0}}, verdict_ok, 1'b1};

    always_comb
    begin
        item0 = ver_item;
        item1 = ver_item;
        if (rep_hit)
            item0 = rep_item;
        if (!accept)
            push_n = 2'd0;
        else
            push_n = 2'(rep_hit) + 2'(byte_ch.last_byte);
    end

    assign count_next = count_reg + {1'b0, push_n} - {{QPTR_W{1'b0}}, pop};

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= scan_arm(DEPTH_ALL);
            offset_reg <= '0;
            depth_reg  <= DEPTH_ALL;
        end
        else if (accept)
        begin
            st_reg     <= st_next;
            offset_reg <= offset_next;
            depth_reg  <= depth_next;
        end
    end

    // Result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + QPTR_W'(push_n);
            rd_reg    <= rd_reg + QPTR_W'(pop);
            count_reg <= count_next;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_reg] <= item0;
        if (push_n == 2'd2)
            queue_reg[wr_reg + QPTR_W'(1)] <= item1;
    end

    assign head = queue_reg[rd_reg];

    assign byte_ch.ready           = (count_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign result_ch.valid         = (count_reg != '0);
    assign result_ch.result_kind   = head[ITEM_W-1];
    assign result_ch.section_id    = head[ITEM_W-2 -: 3];
    assign result_ch.tag_offset    = head[OFFSET_BITS+1:2];
    assign result_ch.message_valid = head[1];
    assign result_ch.last_result   = head[0];

`ifndef SYNTH
    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("result queue overflow");

    // a last byte always leaves a verdict waiting
    a_verdict_queued: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_ch.last_byte |=> count_reg != '0)
        else $error("verdict not queued");

    // tag phase only after a matched descriptor
    a_tag_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == PH_TAG |-> st_reg.check_position != 5'd0)
        else $error("tag phase without check position");

    // a report for a byte that is not last leaves its section marked seen
    a_report_seen: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rep_hit && !byte_ch.last_byte |=> st_reg.seen[$past(rep_id)])
        else $error("report without seen mark");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import amqp_scan_pkg::*;

    localparam int OFFSET_BITS = 32;
    localparam int IDLE_LIMIT  = 3000;   // cycles with no item moving on either channel
    localparam int HOLD_AT     = 40;     // result count that starts the long output stall
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [2:0] depth;
    } byte_item_t;

    typedef struct packed {
        logic                   kind;
        logic [2:0]             sec;
        logic [OFFSET_BITS-1:0] offset;
        logic                   ok;
        logic                   last;
    } scan_result_t;

    logic clk;
    logic rst_n;

    amqp_scan_in_if byte_ch();
    amqp_scan_out_if #(.OFFSET_BITS(OFFSET_BITS)) result_ch();

    amqp_message_section_scanner #(.OFFSET_BITS(OFFSET_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    byte_item_t   bytes_to_send[$];
    scan_result_t expected_results[$];
    logic [7:0]   msg_bytes[$];
    bit           msg_open;          // message ends inside a huge skip
    bit           need_first;        // previous message was cut without a last mark
    int           queued_items = 0;
    int           failures = 0;
    int           send_wait = 0;
    int           send_calm = 0;
    int           take_wait = 0;
    int           take_calm = 0;
    int           hold_left = 0;
    int           results_taken = 0;
    int           idle_cycles = 0;

    // Section scan state mirrored by the predictor
    logic [4:0]             next_check;
    scan_phase_t            phase_now;
    logic [3:0]             desc_bytes;
    logic                   long_form;
    logic [31:0]            len_value;
    logic [2:0]             len_bytes;
    logic [31:0]            skip_count;
    logic [7:0]             sections_done;
    logic [OFFSET_BITS-1:0] msg_offset;
    logic [2:0]             depth_held;
    logic                   msg_invalid;
    logic                   scan_halted;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Wait count for one item; now and then a calm stretch with no waits
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic void rearm_scan();
        next_check    = '0;
        phase_now     = PH_DESC;
        desc_bytes    = '0;
        long_form     = 1'b0;
        len_value     = '0;
        len_bytes     = '0;
        skip_count    = '0;
        sections_done = '0;
        msg_offset    = '0;
        msg_invalid   = 1'b0;
        scan_halted   = (depth_held == DEPTH_NONE);
    endfunction

    function automatic scan_result_t make_result(input logic kind, input logic [2:0] sec,
                                                 input logic [OFFSET_BITS-1:0] off,
                                                 input logic ok);
        scan_result_t r;
        r.kind   = kind;
        r.sec    = sec;
        r.offset = off;
        r.ok     = ok;
        r.last   = 1'b0;
        return r;
    endfunction

    // Advance the section scan by one byte and queue the results it causes
    task automatic predict_scan(input byte_item_t it);
        scan_result_t res[2];
        int           cnt;
        logic [2:0]   sec;
        logic [4:0]   chk;
        logic [4:0]   top_chk;
        logic         code_ok;
        logic         fits;
        cnt = 0;
        if (it.first)
        begin
            depth_held = it.depth;
            rearm_scan();
        end
        if (!scan_halted)
        begin
            case (phase_now)
                PH_DESC:
                begin
                    if (desc_bytes == 0)
                    begin
                        if (it.data == DESC_LEAD) desc_bytes = 4'd1;
                        else scan_halted = 1'b1;
                    end
                    else if (desc_bytes == 1)
                    begin
                        if (it.data == DESC_LONG || it.data == DESC_SHORT)
                        begin
                            long_form  = (it.data == DESC_LONG);
                            desc_bytes = 4'd2;
                        end
                        else
                            scan_halted = 1'b1;
                    end
                    else if (long_form && desc_bytes < LONG_CODE_AT)
                    begin
                        if (it.data == DESC_LEAD) desc_bytes = desc_bytes + 4'd1;
                        else scan_halted = 1'b1;
                    end
                    else
                    begin
                        // code byte: map to a section and its ordered check
                        code_ok = 1'b1;
                        sec = SEC_NONE;
                        if (it.data >= CODE_HEADER && it.data <= CODE_BODYSEQ)
                            sec = 3'(it.data - CODE_HEADER);
                        else if (it.data == CODE_FOOTER)
                            sec = SEC_FOOTER;
                        else
                            code_ok = 1'b0;
                        chk = {1'b0, sec, ~long_form};
                        case (depth_held)
                            DEPTH_NONE: top_chk = 5'd0;
                            3'd6:       top_chk = 5'd13;
                            DEPTH_ALL:  top_chk = 5'd15;
                            default:    top_chk = {1'b0, depth_held, 1'b0} - 5'd1;
                        endcase
                        if (!code_ok || chk < next_check || chk > top_chk)
                            scan_halted = 1'b1;
                        else
                        begin
                            next_check = chk + 5'd1;
                            desc_bytes = '0;
                            phase_now  = PH_TAG;
                        end
                    end
                end
                PH_TAG:
                begin
                    chk = next_check - 5'd1;
                    sec = chk[3:1];
                    case (sec)
                        3'd0, 3'd3, 3'd6:
                            fits = (it.data == TAG_LIST0) || (it.data == TAG_LIST8)
                                || (it.data == TAG_LIST32);
                        3'd5:
                            fits = (it.data == TAG_VBIN8) || (it.data == TAG_VBIN32);
                        default:
                            fits = (it.data == TAG_MAP8) || (it.data == TAG_MAP32);
                    endcase
                    if (!fits || sections_done[sec])
                    begin
                        msg_invalid = 1'b1;
                        scan_halted = 1'b1;
                    end
                    else
                    begin
                        sections_done[sec] = 1'b1;
                        res[cnt] = make_result(KIND_REPORT, sec, msg_offset, 1'b0);
                        cnt++;
                        if (it.last)
                        begin
                            msg_invalid = 1'b1;
                            scan_halted = 1'b1;
                        end
                        else
                        begin
                            len_value = '0;
                            if (it.data == TAG_LIST0)
                                phase_now = PH_DESC;
                            else
                            begin
                                len_bytes = (it.data == TAG_LIST8 || it.data == TAG_MAP8
                                             || it.data == TAG_VBIN8) ? LEN_BYTES_8
                                                                     : LEN_BYTES_32;
                                phase_now = PH_LEN;
                            end
                        end
                    end
                end
                PH_LEN:
                begin
                    len_value = {len_value[23:0], it.data};
                    len_bytes = len_bytes - 3'd1;
                    if (it.last)
                    begin
                        msg_invalid = 1'b1;
                        scan_halted = 1'b1;
                    end
                    else if (len_bytes == 0)
                    begin
                        skip_count = len_value;
                        phase_now  = (len_value == 0) ? PH_DESC : PH_SKIP;
                    end
                end
                default:
                begin
                    skip_count = skip_count - 32'd1;
                    if (skip_count == 0) phase_now = PH_DESC;
                end
            endcase
        end
        if (it.last)
        begin
            res[cnt] = make_result(KIND_VERDICT, SEC_NONE, '0, ~msg_invalid);
            cnt++;
            rearm_scan();
        end
        else
            msg_offset = msg_offset + 1'b1;
        for (int i = 0; i < cnt; i++)
        begin
            if (i == cnt - 1) res[i].last = 1'b1;
            expected_results.push_back(res[i]);
        end
    endtask

    // Queue the built message as items with its marks
    task automatic queue_message(input logic [2:0] depth, input bit mark_first,
                                 input bit mark_last);
        byte_item_t it;
        for (int i = 0; i < msg_bytes.size(); i++)
        begin
            it.data  = msg_bytes[i];
            it.first = mark_first && (i == 0);
            it.last  = mark_last && (i == msg_bytes.size() - 1);
            it.depth = (i == 0) ? depth : 3'($urandom_range(0, 7));
            bytes_to_send.push_back(it);
            queued_items++;
        end
    endtask

    // Descriptor, tag, length and payload of one section
    task automatic put_section(input int sec, input bit long_desc);
        logic [7:0]  tag;
        logic [31:0] len;
        int          pick;
        msg_bytes.push_back(DESC_LEAD);
        if (long_desc)
        begin
            msg_bytes.push_back(DESC_LONG);
            repeat (7) msg_bytes.push_back(DESC_LEAD);
        end
        else
            msg_bytes.push_back(DESC_SHORT);
        msg_bytes.push_back((sec == SEC_FOOTER) ? CODE_FOOTER : CODE_HEADER + 8'(sec));
        pick = $urandom_range(0, 2);
        case (sec)
            0, 3, 6: tag = (pick == 0) ? TAG_LIST0 : (pick == 1) ? TAG_LIST8 : TAG_LIST32;
            5:       tag = pick[0] ? TAG_VBIN8 : TAG_VBIN32;
            default: tag = pick[0] ? TAG_MAP8 : TAG_MAP32;
        endcase
        if ($urandom_range(0, 15) == 0) tag = 8'($urandom_range(0, 255));
        msg_bytes.push_back(tag);
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 10);
        if (tag == TAG_LIST8 || tag == TAG_MAP8 || tag == TAG_VBIN8)
            msg_bytes.push_back(len[7:0]);
        else if (tag == TAG_LIST32 || tag == TAG_MAP32 || tag == TAG_VBIN32)
        begin
            // a huge length leaves the message ending inside the skipped bytes
            if ($urandom_range(0, 11) == 0)
            begin
                len = $urandom;
                msg_open = 1'b1;
            end
            msg_bytes.push_back(len[31:24]);
            msg_bytes.push_back(len[23:16]);
            msg_bytes.push_back(len[15:8]);
            msg_bytes.push_back(len[7:0]);
            if (msg_open) len = $urandom_range(0, 6);
        end
        else
            len = 0;
        repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // One random message: mostly well formed, with shuffles, duplicates and cuts
    task automatic add_message();
        logic [2:0] depth;
        bit         mix;
        bit         long_desc;
        bit         mark_first;
        bit         mark_last;
        int         sec;
        int         cut;
        msg_bytes.delete();
        msg_open = 1'b0;
        depth = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : DEPTH_ALL;
        mix = ($urandom_range(0, 9) == 0);
        for (int slot = 0; slot < 8 && !msg_open; slot++)
        begin
            if ($urandom_range(0, 2) == 0) continue;
            sec = mix ? $urandom_range(0, 7) : slot;
            long_desc = ($urandom_range(0, 3) == 0);
            put_section(sec, long_desc);
            // same section again in short form
            if (long_desc && !msg_open && $urandom_range(0, 4) == 0) put_section(sec, 1'b0);
            if ($urandom_range(0, 24) == 0) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (msg_bytes.size() == 0) msg_bytes.push_back(8'($urandom_range(0, 255)));
        if (!msg_open && $urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        end
        mark_first = need_first || ($urandom_range(0, 7) != 0);
        mark_last = ($urandom_range(0, 11) != 0);
        need_first = !mark_last;
        queue_message(depth, mark_first, mark_last);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_to_send.size() != 0 || expected_results.size() != 0);
    endtask

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        byte_item_t head;
        bit         free;
        if (!rst_n)
        begin
            byte_ch.valid       <= 1'b0;
            byte_ch.data_byte   <= '0;
            byte_ch.first_byte  <= 1'b0;
            byte_ch.last_byte   <= 1'b0;
            byte_ch.depth_limit <= '0;
            depth_held = DEPTH_ALL;
            rearm_scan();
        end
        else
        begin
            free = !(byte_ch.valid && !byte_ch.ready);
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_scan(bytes_to_send.pop_front());
                send_wait = draw_wait(send_calm);
            end
            if (free)
            begin
                if (send_wait == 0 && bytes_to_send.size() != 0)
                begin
                    head = bytes_to_send[0];
                    byte_ch.valid       <= 1'b1;
                    byte_ch.data_byte   <= head.data;
                    byte_ch.first_byte  <= head.first;
                    byte_ch.last_byte   <= head.last;
                    byte_ch.depth_limit <= head.depth;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                    if (send_wait > 0) send_wait--;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : take_results
        scan_result_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d id %0d offset %0d valid %0d",
                           result_ch.result_kind, result_ch.section_id,
                           result_ch.tag_offset, result_ch.message_valid);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, got %0d",
                               want.kind, result_ch.result_kind);
                        failures++;
                    end
                    if (result_ch.section_id !== want.sec)
                    begin
                        $error("section_id: expected %0d, got %0d",
                               want.sec, result_ch.section_id);
                        failures++;
                    end
                    if (result_ch.tag_offset !== want.offset)
                    begin
                        $error("tag_offset: expected %0d, got %0d",
                               want.offset, result_ch.tag_offset);
                        failures++;
                    end
                    if (result_ch.message_valid !== want.ok)
                    begin
                        $error("message_valid: expected %0d, got %0d",
                               want.ok, result_ch.message_valid);
                        failures++;
                    end
                    if (result_ch.last_result !== want.last)
                    begin
                        $error("last_result: expected %0d, got %0d",
                               want.last, result_ch.last_result);
                        failures++;
                    end
                end
                results_taken++;
                take_wait = draw_wait(take_calm);
                // one long stall so the result queue fills and input backs up
                if (results_taken == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (take_wait > 0)
            begin
                take_wait--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles where no item moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset, directed messages, then two random phases with a full drain between
    initial
    begin
        rst_n = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.first_byte  = 1'b0;
        byte_ch.last_byte   = 1'b0;
        byte_ch.depth_limit = '0;
        result_ch.ready     = 1'b0;
        need_first = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // header ending on its tag: reported, then invalid
        msg_bytes = '{DESC_LEAD, DESC_SHORT, CODE_HEADER, TAG_LIST0};
        queue_message(DEPTH_ALL, 1'b1, 1'b1);
        // body data with 4-byte length, ends in a descriptor: valid
        msg_bytes = '{DESC_LEAD, DESC_SHORT, CODE_HEADER + 8'h05, TAG_VBIN32,
                      8'h00, 8'h00, 8'h00, 8'h01, 8'hff, DESC_LEAD};
        queue_message(DEPTH_ALL, 1'b1, 1'b0);
        msg_bytes = '{DESC_LEAD};
        queue_message(DEPTH_ALL, 1'b0, 1'b1);
        // no first mark; map section with a list tag: invalid
        msg_bytes = '{DESC_LEAD, DESC_SHORT, CODE_HEADER + 8'h01, TAG_LIST0};
        queue_message(DEPTH_NONE, 1'b0, 1'b1);
        // footer ending in its length byte: invalid
        msg_bytes = '{DESC_LEAD, DESC_SHORT, CODE_FOOTER, TAG_MAP32, 8'h00};
        queue_message(DEPTH_ALL, 1'b1, 1'b1);
        // depth none, single byte
        msg_bytes = '{8'hff};
        queue_message(DEPTH_NONE, 1'b1, 1'b1);
        wait_drained();

        while (queued_items < 200) add_message();
        wait_drained();
        while (queued_items < 400) add_message();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
